@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never be seen at a rising clock edge outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

@@ rtl/core/cci_pkg.sv @@
package cci_pkg;

  localparam int CW    = 32;   // coordinate code
  localparam int RW    = 31;   // radius code
  localparam int DXW   = 33;   // centre difference, signed
  localparam int D2W   = 66;   // squared centre distance
  localparam int NW    = 67;   // ru^2 - rv^2 + d^2, signed
  localparam int KW    = 128;  // 4 * d^2 * h^2
  localparam int SRW   = 64;   // floor(sqrt(K))
  localparam int AW    = 104;  // numerators of the point coordinates
  localparam int DENW  = 67;   // 2 * d^2
  localparam int QW    = 33;   // quotient magnitude
  localparam int PW    = 35;   // coordinate before clipping
  localparam int LANES = 4;

  localparam logic signed [CW-1:0] CMAX = 32'sh7fff_ffff;
  localparam logic signed [CW-1:0] CMIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    OC_NONE  = 2'd0,
    OC_ONE   = 2'd1,
    OC_TWO   = 2'd2,
    OC_COINC = 2'd3
  } outcome_t;

  // Geometry that rides along the square root pipeline.
  typedef struct packed {
    logic signed [CW-1:0]  cux;
    logic signed [CW-1:0]  cuy;
    logic signed [DXW-1:0] dx;
    logic signed [DXW-1:0] dy;
    logic signed [NW-1:0]  n;
    logic [D2W-1:0]        d2;
    outcome_t              pre;
  } cci_geo_t;

  // Side data that rides along the divider.
  typedef struct packed {
    logic signed [CW-1:0] cux;
    logic signed [CW-1:0] cuy;
    outcome_t             outcome;
    logic [LANES-1:0]     neg;
  } cci_dside_t;

  typedef struct packed {
    outcome_t             outcome;
    logic signed [CW-1:0] p1x;
    logic signed [CW-1:0] p1y;
    logic signed [CW-1:0] p2x;
    logic signed [CW-1:0] p2y;
    logic                 saturated;
  } cci_res_t;

endpackage

@@ rtl/core/cci_in_if.sv @@
interface cci_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] first_center_x;
  logic signed [31:0] first_center_y;
  logic [30:0]        first_radius;
  logic signed [31:0] second_center_x;
  logic signed [31:0] second_center_y;
  logic [30:0]        second_radius;

  modport source (
    output valid, first_center_x, first_center_y, first_radius,
    output second_center_x, second_center_y, second_radius,
    input  ready
  );

  modport sink (
    input  valid, first_center_x, first_center_y, first_radius,
    input  second_center_x, second_center_y, second_radius,
    output ready
  );
endinterface

@@ rtl/core/cci_out_if.sv @@
interface cci_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         outcome;
  logic signed [31:0] point_one_x;
  logic signed [31:0] point_one_y;
  logic signed [31:0] point_two_x;
  logic signed [31:0] point_two_y;
  logic               saturated;

  modport source (
    output valid, outcome, point_one_x, point_one_y, point_two_x, point_two_y, saturated,
    input  ready
  );

  modport sink (
    input  valid, outcome, point_one_x, point_one_y, point_two_x, point_two_y, saturated,
    output ready
  );
endinterface

@@ rtl/core/cci_sqrt.sv @@
module cci_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [cci_pkg::KW-1:0]  in_k,
  input  cci_pkg::cci_geo_t       in_geo,
  output logic                    out_valid,
  output logic [cci_pkg::SRW-1:0] out_root,
  output cci_pkg::cci_geo_t       out_geo
);
  import cci_pkg::*;

  logic           vld_r  [SRW];
  logic [KW-1:0]  rem_r  [SRW];
  logic [SRW-1:0] root_r [SRW];
  cci_geo_t       geo_r  [SRW];

  // One result bit per stage, most significant first; rem holds K - root^2.
  for (genvar j = 0; j < SRW; j++) begin : g_stage
    localparam int B = SRW - 1 - j;
    logic           v_s;
    logic [KW-1:0]  rem_s;
    logic [SRW-1:0] root_s;
    cci_geo_t       geo_s;
    logic [KW:0]    trial;
    logic [KW-1:0]  rem_n;
    logic [SRW-1:0] root_n;

    if (j == 0) begin : g_head
      assign v_s    = in_valid;
      assign rem_s  = in_k;
      assign root_s = '0;
      assign geo_s  = in_geo;
    end else begin : g_body
      assign v_s    = vld_r[j-1];
      assign rem_s  = rem_r[j-1];
      assign root_s = root_r[j-1];
      assign geo_s  = geo_r[j-1];
    end

    // (root + 2^B)^2 - root^2 = root * 2^(B+1) + 2^(2B)
    assign trial = ((KW+1)'(root_s) << (B + 1)) + ((KW+1)'(1) << (2 * B));

    always_comb begin
      rem_n  = rem_s;
      root_n = root_s;
      if ({1'b0, rem_s} >= trial) begin
        rem_n     = rem_s - trial[KW-1:0];
        root_n[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_n;
        root_r[j] <= root_n;
        geo_r[j]  <= geo_s;
      end
    end
  end

  assign out_valid = vld_r[SRW-1];
  assign out_root  = root_r[SRW-1];
  assign out_geo   = geo_r[SRW-1];

endmodule

@@ rtl/core/cci_div.sv @@
module cci_div (
  input  logic                                             clk,
  input  logic                                             rst,
  input  logic                                             en,
  input  logic                                             in_valid,
  input  logic [cci_pkg::LANES-1:0][cci_pkg::AW-1:0]       in_m,
  input  logic [cci_pkg::DENW-1:0]                         in_den,
  input  cci_pkg::cci_dside_t                              in_side,
  output logic                                             out_valid,
  output logic [cci_pkg::LANES-1:0][cci_pkg::QW-1:0]       out_q,
  output cci_pkg::cci_dside_t                              out_side
);
  import cci_pkg::*;

  logic                         vld_r  [QW];
  logic [LANES-1:0][AW-1:0]     rem_r  [QW];
  logic [LANES-1:0][QW-1:0]     q_r    [QW];
  logic [DENW-1:0]              den_r  [QW];
  cci_dside_t                   side_r [QW];

  // Restoring division, one quotient bit per stage for all lanes at once.
  // The quotient is known to fit QW bits, so the dividend starts below den << QW.
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic                     v_s;
    logic [LANES-1:0][AW-1:0] rem_s;
    logic [LANES-1:0][QW-1:0] q_s;
    logic [DENW-1:0]          den_s;
    cci_dside_t               side_s;
    logic [AW-1:0]            dshift;
    logic [LANES-1:0][AW-1:0] rem_n;
    logic [LANES-1:0][QW-1:0] q_n;

    if (j == 0) begin : g_head
      assign v_s    = in_valid;
      assign rem_s  = in_m;
      assign q_s    = '0;
      assign den_s  = in_den;
      assign side_s = in_side;
    end else begin : g_body
      assign v_s    = vld_r[j-1];
      assign rem_s  = rem_r[j-1];
      assign q_s    = q_r[j-1];
      assign den_s  = den_r[j-1];
      assign side_s = side_r[j-1];
    end

    assign dshift = AW'(den_s) << B;

    always_comb begin
      rem_n = rem_s;
      q_n   = q_s;
      for (int l = 0; l < LANES; l++) begin
        if (rem_s[l] >= dshift) begin
          rem_n[l]  = rem_s[l] - dshift;
          q_n[l][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_r[j] <= 1'b0;
      end else if (en) begin
        vld_r[j] <= v_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= rem_n;
        q_r[j]    <= q_n;
        den_r[j]  <= den_s;
        side_r[j] <= side_s;
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_q     = q_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

@@ rtl/core/cci_outq.sv @@
module cci_outq (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  input  cci_pkg::cci_res_t push_res,
  output logic              advance,
  cci_out_if.source         points
);
  import cci_pkg::*;

  cci_res_t   ent [2];
  cci_res_t   head;
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  // The pipeline moves unless both entries hold words that are not being taken.
  assign advance = (cnt != 2'd2) || points.ready;
  assign push    = push_valid && advance;
  assign pop     = points.valid && points.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) ent[wp] <= push_res;
  end

  assign head               = ent[rp];
  assign points.valid       = (cnt != 2'd0);
  assign points.outcome     = head.outcome;
  assign points.point_one_x = head.p1x;
  assign points.point_one_y = head.p1y;
  assign points.point_two_x = head.p2x;
  assign points.point_two_y = head.p2y;
  assign points.saturated   = head.saturated;

endmodule

@@ rtl/core/circle_circle_intersection_top.sv @@
// Circle-circle intersection: each word on circles carries two circles (center and radius as
// raw fixed-point codes) and yields one word on points with the outcome and up to two meeting
// points, rounded to nearest and clipped to 32 bits. A new word is taken in every cycle unless the
// input stalls; the result's delay is set by the 64-stage square root and the
// 33-stage four-lane divider. A two-word output queue lets the pipeline keep taking words while
// one result waits; the input stalls only when both queue entries are held.
`include "assert_macros.svh"

module circle_circle_intersection_top (
  input  logic      clk,
  input  logic      rst,
  cci_in_if.sink    circles,
  cci_out_if.source points
);
  import cci_pkg::*;

  function automatic logic signed [PW-1:0] coord_sum(input logic neg,
                                                     input logic signed [CW-1:0] base,
                                                     input logic [QW-1:0] q);
    logic signed [PW-1:0] b;
    logic signed [PW-1:0] m;
    b = PW'(base);
    m = $signed({2'b00, q});
    return neg ? b - m : b + m;
  endfunction

  function automatic logic signed [CW-1:0] clip(input logic signed [PW-1:0] c);
    logic ovf;
    ovf = (c[PW-1:CW-1] != {(PW-CW+1){c[PW-1]}});
    if (ovf) return c[PW-1] ? CMIN : CMAX;
    return c[CW-1:0];
  endfunction

  function automatic logic clipped(input logic signed [PW-1:0] c);
    return (c[PW-1:CW-1] != {(PW-CW+1){c[PW-1]}});
  endfunction

  logic en;
  logic [6:0] va;
  logic [4:0] vb;
  logic vf;

  // stage 1: input capture
  logic signed [CW-1:0] s1_cux, s1_cuy, s1_cvx, s1_cvy;
  logic [RW-1:0] s1_ru, s1_rv;
  // stage 2
  logic signed [DXW-1:0] dx_c, dy_c;
  logic signed [DXW-1:0] s2_dx, s2_dy;
  logic [DXW-1:0] s2_mx, s2_my;
  logic [CW-1:0] s2_sum;
  logic [RW-1:0] s2_df, s2_ru, s2_rv;
  logic signed [CW-1:0] s2_cux, s2_cuy;
  logic s2_eqr;
  // stage 3
  logic [D2W-1:0] s3_mx2, s3_my2;
  logic [63:0] s3_sq1;
  logic [61:0] s3_sq0, s3_ru2, s3_rv2;
  logic signed [DXW-1:0] s3_dx, s3_dy;
  logic signed [CW-1:0] s3_cux, s3_cuy;
  logic s3_eqr;
  // stage 4
  logic [D2W-1:0] s4_d2;
  logic signed [62:0] s4_rr;
  logic [63:0] s4_sq1;
  logic [61:0] s4_sq0;
  logic signed [DXW-1:0] s4_dx, s4_dy;
  logic signed [CW-1:0] s4_cux, s4_cuy;
  logic s4_eqr;
  // stage 5
  logic meet;
  outcome_t pre;
  cci_geo_t s5_geo;
  logic [63:0] s5_ka, s5_kb;
  // stage 6 and 7
  logic [63:0] s6_pp00, s6_pp01, s6_pp10, s6_pp11;
  cci_geo_t s6_geo;
  logic [KW-1:0] s7_k;
  cci_geo_t s7_geo;
  // square root
  logic sq_valid;
  logic [SRW-1:0] sq_root;
  cci_geo_t sq_geo;
  // stage 8 to 12
  logic signed [67:0] s8_xnl, s8_ynl;
  logic signed [65:0] s8_xnh, s8_ynh, s8_ysl, s8_ysh, s8_xsl, s8_xsh;
  logic signed [CW-1:0] s8_cux, s8_cuy;
  logic [D2W-1:0] s8_d2;
  outcome_t s8_oc;
  logic signed [AW-1:0] s9_ax, s9_ay, s9_ox, s9_oy;
  logic signed [CW-1:0] s9_cux, s9_cuy;
  logic [D2W-1:0] s9_d2;
  outcome_t s9_oc;
  logic signed [AW-1:0] s10_num [LANES];
  logic signed [CW-1:0] s10_cux, s10_cuy;
  logic [D2W-1:0] s10_d2;
  outcome_t s10_oc;
  logic signed [AW-1:0] s11_v [LANES];
  logic signed [CW-1:0] s11_cux, s11_cuy;
  logic [D2W-1:0] s11_d2;
  outcome_t s11_oc;
  logic [LANES-1:0][AW-1:0] s12_m;
  logic [DENW-1:0] s12_den;
  cci_dside_t s12_side;
  // divider and final stage
  logic dv_valid;
  logic [LANES-1:0][QW-1:0] dv_q;
  cci_dside_t dv_side;
  logic signed [PW-1:0] sf_c [LANES];
  outcome_t sf_oc;
  logic use1, use2;
  cci_res_t res;

  assign circles.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
      vb <= '0;
      vf <= 1'b0;
    end else if (en) begin
      va <= {va[5:0], circles.valid};
      vb <= {vb[3:0], sq_valid};
      vf <= dv_valid;
    end
  end

  assign dx_c = DXW'(s1_cvx) - DXW'(s1_cux);
  assign dy_c = DXW'(s1_cvy) - DXW'(s1_cuy);

  // Circles meet only when (ru - rv)^2 <= d^2 <= (ru + rv)^2.
  always_comb begin
    meet = (s4_d2 <= D2W'(s4_sq1)) && (s4_d2 >= D2W'(s4_sq0));
    if (s4_d2 == '0) begin
      pre = s4_eqr ? OC_COINC : OC_NONE;
    end else if (meet) begin
      pre = OC_TWO;
    end else begin
      pre = OC_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_cux <= circles.first_center_x;
      s1_cuy <= circles.first_center_y;
      s1_ru  <= circles.first_radius;
      s1_cvx <= circles.second_center_x;
      s1_cvy <= circles.second_center_y;
      s1_rv  <= circles.second_radius;

      s2_dx  <= dx_c;
      s2_dy  <= dy_c;
      s2_mx  <= dx_c[DXW-1] ? DXW'(-dx_c) : DXW'(dx_c);
      s2_my  <= dy_c[DXW-1] ? DXW'(-dy_c) : DXW'(dy_c);
      s2_sum <= CW'(s1_ru) + CW'(s1_rv);
      s2_df  <= (s1_ru > s1_rv) ? s1_ru - s1_rv : s1_rv - s1_ru;
      s2_eqr <= (s1_ru == s1_rv);
      s2_ru  <= s1_ru;
      s2_rv  <= s1_rv;
      s2_cux <= s1_cux;
      s2_cuy <= s1_cuy;

      s3_mx2 <= s2_mx * s2_mx;
      s3_my2 <= s2_my * s2_my;
      s3_sq1 <= s2_sum * s2_sum;
      s3_sq0 <= s2_df * s2_df;
      s3_ru2 <= s2_ru * s2_ru;
      s3_rv2 <= s2_rv * s2_rv;
      s3_dx  <= s2_dx;
      s3_dy  <= s2_dy;
      s3_cux <= s2_cux;
      s3_cuy <= s2_cuy;
      s3_eqr <= s2_eqr;

      s4_d2  <= s3_mx2 + s3_my2;
      s4_rr  <= $signed({1'b0, s3_ru2}) - $signed({1'b0, s3_rv2});
      s4_sq1 <= s3_sq1;
      s4_sq0 <= s3_sq0;
      s4_dx  <= s3_dx;
      s4_dy  <= s3_dy;
      s4_cux <= s3_cux;
      s4_cuy <= s3_cuy;
      s4_eqr <= s3_eqr;

      s5_geo.cux <= s4_cux;
      s5_geo.cuy <= s4_cuy;
      s5_geo.dx  <= s4_dx;
      s5_geo.dy  <= s4_dy;
      s5_geo.n   <= NW'(s4_rr) + $signed({1'b0, s4_d2});
      s5_geo.d2  <= s4_d2;
      s5_geo.pre <= pre;
      s5_ka      <= s4_sq1 - s4_d2[63:0];
      s5_kb      <= s4_d2[63:0] - 64'(s4_sq0);

      // K = (sq1 - d2) * (d2 - sq0) from four 32x32 partial products.
      s6_pp00 <= s5_ka[31:0] * s5_kb[31:0];
      s6_pp01 <= s5_ka[31:0] * s5_kb[63:32];
      s6_pp10 <= s5_ka[63:32] * s5_kb[31:0];
      s6_pp11 <= s5_ka[63:32] * s5_kb[63:32];
      s6_geo  <= s5_geo;

      s7_k   <= KW'(s6_pp00) + (KW'(s6_pp01) << 32) + (KW'(s6_pp10) << 32)
              + (KW'(s6_pp11) << 64);
      s7_geo <= s6_geo;

      s8_xnl <= $signed(sq_geo.dx) * $signed({1'b0, sq_geo.n[33:0]});
      s8_xnh <= $signed(sq_geo.dx) * $signed(sq_geo.n[NW-1:34]);
      s8_ynl <= $signed(sq_geo.dy) * $signed({1'b0, sq_geo.n[33:0]});
      s8_ynh <= $signed(sq_geo.dy) * $signed(sq_geo.n[NW-1:34]);
      s8_ysl <= $signed(sq_geo.dy) * $signed({1'b0, sq_root[31:0]});
      s8_ysh <= $signed(sq_geo.dy) * $signed({1'b0, sq_root[63:32]});
      s8_xsl <= $signed(sq_geo.dx) * $signed({1'b0, sq_root[31:0]});
      s8_xsh <= $signed(sq_geo.dx) * $signed({1'b0, sq_root[63:32]});
      s8_cux <= sq_geo.cux;
      s8_cuy <= sq_geo.cuy;
      s8_d2  <= sq_geo.d2;
      // A zero root means K is zero: the circles touch.
      s8_oc  <= (sq_geo.pre == OC_TWO && sq_root == '0) ? OC_ONE : sq_geo.pre;

      s9_ax  <= (AW'(s8_xnh) <<< 34) + AW'(s8_xnl);
      s9_ay  <= (AW'(s8_ynh) <<< 34) + AW'(s8_ynl);
      s9_ox  <= (AW'(s8_ysh) <<< 32) + AW'(s8_ysl);
      s9_oy  <= (AW'(s8_xsh) <<< 32) + AW'(s8_xsl);
      s9_cux <= s8_cux;
      s9_cuy <= s8_cuy;
      s9_d2  <= s8_d2;
      s9_oc  <= s8_oc;

      s10_num[0] <= s9_ax - s9_ox;
      s10_num[1] <= s9_ay + s9_oy;
      s10_num[2] <= s9_ax + s9_ox;
      s10_num[3] <= s9_ay - s9_oy;
      s10_cux    <= s9_cux;
      s10_cuy    <= s9_cuy;
      s10_d2     <= s9_d2;
      s10_oc     <= s9_oc;

      // Adding d^2 to the numerator turns the floor of the quotient into rounding.
      for (int i = 0; i < LANES; i++) begin
        s11_v[i] <= s10_num[i] + $signed(AW'(s10_d2));
      end
      s11_cux <= s10_cux;
      s11_cuy <= s10_cuy;
      s11_d2  <= s10_d2;
      s11_oc  <= s10_oc;

      // A negative value divides as its magnitude plus den - 1, then is negated.
      for (int i = 0; i < LANES; i++) begin
        s12_m[i]        <= s11_v[i][AW-1] ? AW'({s11_d2, 1'b0}) + ~s11_v[i] : s11_v[i];
        s12_side.neg[i] <= s11_v[i][AW-1];
      end
      s12_den          <= {s11_d2, 1'b0};
      s12_side.cux     <= s11_cux;
      s12_side.cuy     <= s11_cuy;
      s12_side.outcome <= s11_oc;

      sf_c[0] <= coord_sum(dv_side.neg[0], dv_side.cux, dv_q[0]);
      sf_c[1] <= coord_sum(dv_side.neg[1], dv_side.cuy, dv_q[1]);
      sf_c[2] <= coord_sum(dv_side.neg[2], dv_side.cux, dv_q[2]);
      sf_c[3] <= coord_sum(dv_side.neg[3], dv_side.cuy, dv_q[3]);
      sf_oc   <= dv_side.outcome;
    end
  end

  cci_sqrt u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (va[6]),
    .in_k      (s7_k),
    .in_geo    (s7_geo),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_geo   (sq_geo)
  );

  cci_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vb[4]),
    .in_m      (s12_m),
    .in_den    (s12_den),
    .in_side   (s12_side),
    .out_valid (dv_valid),
    .out_q     (dv_q),
    .out_side  (dv_side)
  );

  always_comb begin
    use1 = (sf_oc == OC_ONE) || (sf_oc == OC_TWO);
    use2 = (sf_oc == OC_TWO);
    res.outcome   = sf_oc;
    res.p1x       = use1 ? clip(sf_c[0]) : '0;
    res.p1y       = use1 ? clip(sf_c[1]) : '0;
    res.p2x       = use2 ? clip(sf_c[2]) : '0;
    res.p2y       = use2 ? clip(sf_c[3]) : '0;
    res.saturated = (use1 && (clipped(sf_c[0]) || clipped(sf_c[1])))
                 || (use2 && (clipped(sf_c[2]) || clipped(sf_c[3])));
  end

  cci_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (vf),
    .push_res   (res),
    .advance    (en),
    .points     (points)
  );

  `ASSERT_CLK(a_no_point_fields_zero,
    points.valid && (points.outcome == OC_NONE || points.outcome == OC_COINC) |->
      !points.saturated && points.point_one_x == '0 && points.point_one_y == '0
      && points.point_two_x == '0 && points.point_two_y == '0,
    "unused point fields not zero")
  `ASSERT_CLK(a_touch_second_zero,
    points.valid && points.outcome == OC_ONE |->
      points.point_two_x == '0 && points.point_two_y == '0,
    "second point set for a touching pair")
  `ASSERT_NEVER(a_stall_without_result, !circles.ready && !points.valid, "input stalled with no result waiting")

endmodule

@@ dv/tb.sv @@
module tb;
  import cci_pkg::*;

  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    logic signed [31:0] ux;
    logic signed [31:0] uy;
    logic [30:0]        ru;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [30:0]        rv;
  } circle_pair_t;

  localparam int STALL_LIMIT = 3000;
  localparam int HOLD_CYCLES = 400;

  logic clk;
  logic rst;

  cci_in_if  circ ();
  cci_out_if pts ();

  circle_circle_intersection_top dut (
    .clk     (clk),
    .rst     (rst),
    .circles (circ),
    .points  (pts)
  );

  circle_pair_t pending_pairs[$];
  cci_res_t     expected_meets[$];
  int           pairs_total;
  int           pairs_taken;
  int           mismatches;
  int           idle_cycles;
  int           send_idle_pct;
  int           recv_idle_pct;
  int           hold_left;
  logic         hold_done;
  logic         in_fire;

  // Rounds num / (2*d2) to nearest, ties upward, adds base and clips to 32 bits.
  function automatic logic signed [31:0] place(wide_t base, wide_t num, wide_t d2,
                                               ref logic sat);
    wide_t v;
    wide_t den;
    wide_t q;
    wide_t p;
    v   = num + d2;
    den = d2 + d2;
    q   = v / den;
    if (v < 0 && q * den != v) begin
      q = q - 1;
    end
    p = base + q;
    if (p > wide_t'(32'sh7fff_ffff)) begin
      sat = 1'b1;
      return CMAX;
    end
    if (p < wide_t'(CMIN)) begin
      sat = 1'b1;
      return CMIN;
    end
    return p[31:0];
  endfunction

  function automatic cci_res_t predict_meet(circle_pair_t c);
    wide_t ux, uy, ru, rv, dx, dy, d2, s1, s0, df, k, sr, t, n, ax, ay, ox, oy;
    logic  sat;
    cci_res_t r;
    ux = wide_t'(c.ux);
    uy = wide_t'(c.uy);
    ru = wide_t'({1'b0, c.ru});
    rv = wide_t'({1'b0, c.rv});
    dx = wide_t'(c.vx) - ux;
    dy = wide_t'(c.vy) - uy;
    d2 = dx * dx + dy * dy;
    sat = 1'b0;
    r = '0;
    r.outcome = OC_NONE;
    if (d2 == 0) begin
      r.outcome = (ru == rv) ? OC_COINC : OC_NONE;
    end else begin
      s1 = (ru + rv) * (ru + rv);
      df = (ru > rv) ? ru - rv : rv - ru;
      s0 = df * df;
      if (d2 <= s1 && d2 >= s0) begin
        k  = (s1 - d2) * (d2 - s0);
        sr = 0;
        for (int b = 63; b >= 0; b--) begin
          t = sr | (wide_t'(1) << b);
          if (t * t <= k) begin
            sr = t;
          end
        end
        n  = ru * ru - rv * rv + d2;
        ax = dx * n;
        ay = dy * n;
        ox = dy * sr;
        oy = dx * sr;
        r.p1x = place(ux, ax - ox, d2, sat);
        r.p1y = place(uy, ay + oy, d2, sat);
        if (k == 0) begin
          r.outcome = OC_ONE;
        end else begin
          r.outcome = OC_TWO;
          r.p2x = place(ux, ax + ox, d2, sat);
          r.p2y = place(uy, ay - oy, d2, sat);
        end
      end
    end
    r.saturated = sat;
    return r;
  endfunction

  function automatic circle_pair_t make_pair(int ux, int uy, int ru, int vx, int vy, int rv);
    circle_pair_t c;
    c.ux = ux;
    c.uy = uy;
    c.ru = ru[30:0];
    c.vx = vx;
    c.vy = vy;
    c.rv = rv[30:0];
    return c;
  endfunction

  function automatic logic signed [31:0] rand_center();
    case ($urandom_range(3))
      0:       return 32'sh7fff_ffff - $urandom_range(1 << 20);
      1:       return 32'sh8000_0000 + $urandom_range(1 << 20);
      2:       return $urandom;
      default: return $signed($urandom) >>> $urandom_range(31);
    endcase
  endfunction

  // Mostly pairs whose center offset on each axis is at most the radius sum, some touching or concentric.
  function automatic circle_pair_t rand_pair();
    circle_pair_t c;
    int unsigned  ru, rv, sum, ax, ay;
    logic signed [31:0] ox, oy;
    int           kind;
    kind = $urandom_range(99);
    if (kind < 15) begin
      c.ux = $urandom;
      c.uy = $urandom;
      c.ru = 31'($urandom);
      c.vx = $urandom;
      c.vy = $urandom;
      c.rv = 31'($urandom);
      return c;
    end
    ru  = $urandom & ((32'd1 << $urandom_range(30, 1)) - 1);
    rv  = (kind < 25) ? ru : ($urandom & ((32'd1 << $urandom_range(30, 1)) - 1));
    sum = ru + rv;
    ax  = $urandom % (sum + 1);
    ay  = $urandom % (sum + 1);
    ox  = $urandom_range(1) ? -$signed(ax) : $signed(ax);
    oy  = $urandom_range(1) ? -$signed(ay) : $signed(ay);
    if (kind < 35) begin
      // Touching circles along an axis.
      ox = $urandom_range(1) ? $signed(sum) : $signed(ru > rv ? ru - rv : rv - ru);
      oy = 0;
    end else if (kind < 40) begin
      ox = 0;
      oy = 0;
    end
    c.ux = rand_center();
    c.uy = rand_center();
    c.ru = ru[30:0];
    c.vx = c.ux + ox;
    c.vy = c.uy + oy;
    c.rv = rv[30:0];
    return c;
  endfunction

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    circ.valid = 1'b0;
    circ.first_center_x = '0;
    circ.first_center_y = '0;
    circ.first_radius = '0;
    circ.second_center_x = '0;
    circ.second_center_y = '0;
    circ.second_radius = '0;
    pts.ready = 1'b0;
    rst = 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
  end

  initial begin
    pending_pairs.push_back(make_pair(0, 0, 65536, 0, 0, 65536));
    pending_pairs.push_back(make_pair(0, 0, 0, 0, 0, 0));
    pending_pairs.push_back(make_pair(5, 5, 3, 5, 5, 4));
    pending_pairs.push_back(make_pair(0, 0, 1, 2, 0, 1));
    pending_pairs.push_back(make_pair(0, 0, 3, 1, 0, 2));
    pending_pairs.push_back(make_pair(0, 0, 5, 6, 8, 5));
    pending_pairs.push_back(make_pair(0, 0, 1, 100, 0, 1));
    pending_pairs.push_back(make_pair(0, 0, 100, 1, 0, 2));
    pending_pairs.push_back(make_pair(0, 0, 0, 1, 0, 0));
    pending_pairs.push_back(make_pair(0, 0, 65536, 65536, 0, 65536));
    pending_pairs.push_back(make_pair(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                                      32'h7fffffff, 32'h80000000, 32'h7fffffff));
    pending_pairs.push_back(make_pair(32'h80000000, 32'h80000000, 32'h7fffffff,
                                      32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
    pending_pairs.push_back(make_pair(32'h80000000, 0, 32'h7fffffff,
                                      32'h7fffffff, 0, 32'h7fffffff));
    pending_pairs.push_back(make_pair(32'h7fffffff, 0, 32'h7fffffff,
                                      32'h7ffffffe, 1, 32'h7fffffff));
    pending_pairs.push_back(make_pair(-10, -10, 7, 10, 10, 30));
    pending_pairs.push_back(make_pair(1000, -2000, 300, 1300, -2400, 200));
    pending_pairs.push_back(make_pair(-3, 4, 5, 3, -4, 5));
    pending_pairs.push_back(make_pair(32'h80000000, 32'h80000000, 0,
                                      32'h80000000, 32'h80000000, 0));
    for (int i = 0; i < 950; i++) begin
      pending_pairs.push_back(rand_pair());
    end
    pairs_total = pending_pairs.size();
  end

  always @(posedge clk) begin
    in_fire <= !rst && circ.valid && circ.ready;
    if (!rst && circ.valid && circ.ready) begin
      expected_meets.push_back(predict_meet('{circ.first_center_x, circ.first_center_y,
                                              circ.first_radius, circ.second_center_x,
                                              circ.second_center_y, circ.second_radius}));
      pairs_taken <= pairs_taken + 1;
    end
  end

  always @(posedge clk) begin
    if (pairs_taken < 320) begin
      send_idle_pct <= 11;
      recv_idle_pct <= 57;
    end else if (pairs_taken < 640) begin
      send_idle_pct <= 57;
      recv_idle_pct <= 11;
    end else begin
      send_idle_pct <= 0;
      recv_idle_pct <= 0;
    end
  end

  always @(negedge clk) begin
    circle_pair_t c;
    if (rst) begin
      circ.valid <= 1'b0;
    end else if (!circ.valid || in_fire) begin
      if (pending_pairs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        c = pending_pairs.pop_front();
        circ.first_center_x  <= c.ux;
        circ.first_center_y  <= c.uy;
        circ.first_radius    <= c.ru;
        circ.second_center_x <= c.vx;
        circ.second_center_y <= c.vy;
        circ.second_radius   <= c.rv;
        circ.valid <= 1'b1;
      end else begin
        circ.valid <= 1'b0;
      end
    end
  end

  // Once in the last phase the receiver holds off long enough to fill the block.
  always @(negedge clk) begin
    if (rst) begin
      pts.ready <= 1'b0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && pairs_taken >= 700) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      pts.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pts.ready <= 1'b0;
    end else begin
      pts.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cci_res_t want;
    if (!rst && pts.valid && pts.ready) begin
      if (expected_meets.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
          $display("unexpected result word: outcome %0d", pts.outcome);
        end
      end else begin
        want = expected_meets.pop_front();
        if (pts.outcome !== want.outcome || pts.point_one_x !== want.p1x ||
            pts.point_one_y !== want.p1y || pts.point_two_x !== want.p2x ||
            pts.point_two_y !== want.p2y || pts.saturated !== want.saturated) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("mismatch: expected oc %0d p1 (%0d,%0d) p2 (%0d,%0d) sat %0b",
                     want.outcome, want.p1x, want.p1y, want.p2x, want.p2y,
                     want.saturated);
            $display("          got      oc %0d p1 (%0d,%0d) p2 (%0d,%0d) sat %0b",
                     pts.outcome, pts.point_one_x, pts.point_one_y, pts.point_two_x,
                     pts.point_two_y, pts.saturated);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (circ.valid && circ.ready) || (pts.valid && pts.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  initial begin
    mismatches  = 0;
    pairs_taken = 0;
    @(negedge rst);
    while (pairs_taken < pairs_total || expected_meets.size() > 0) begin
      @(posedge clk);
    end
    repeat (150) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
